>>> rtl/crcfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package crcfd_pkg;

	localparam int CFG_W = 16;
	localparam int CFG_IDX_W = 2;

	localparam logic [7:0] SYNC_A = 8'hA5;
	localparam logic [7:0] SYNC_B = 8'h5A;
	localparam logic [15:0] CRC_POLY = 16'h1021;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;

	localparam logic [7:0] VERSION_RST = 8'd1;
	localparam logic [15:0] PAYLOAD_LIMIT_RST = 16'd256;
	localparam logic [15:0] TIMEOUT_LIMIT_RST = 16'd20;

	typedef enum logic [1:0] {
		CFG_VERSION = 2'd0,
		CFG_PAYLOAD_LIMIT = 2'd1,
		CFG_TIMEOUT_LIMIT = 2'd2
	} cfg_idx_t;

	typedef enum logic [1:0] {
		MODE_RX = 2'd0,
		MODE_TIME = 2'd1,
		MODE_ABORT = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		ST_NEED_MORE = 3'd0,
		ST_FRAME_READY = 3'd1,
		ST_CRC_ERR = 3'd2,
		ST_VERSION_ERR = 3'd3,
		ST_LENGTH_ERR = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		PH_SYNC0 = 4'd0,
		PH_SYNC1 = 4'd1,
		PH_VER = 4'd2,
		PH_TYPE = 4'd3,
		PH_SEQLO = 4'd4,
		PH_SEQHI = 4'd5,
		PH_LENLO = 4'd6,
		PH_LENHI = 4'd7,
		PH_PAY = 4'd8,
		PH_CRCLO = 4'd9,
		PH_CRCHI = 4'd10
	} phase_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [7:0] rx_byte;
		logic [31:0] now_ms;
	} in_t;

	typedef struct packed {
		status_t status;
		logic payload_valid;
		logic [7:0] payload_byte;
		logic [15:0] payload_index;
		logic [7:0] frame_type;
		logic [15:0] frame_seq;
		logic [15:0] frame_len;
		logic timeout_hit;
	} out_t;

	typedef struct packed {
		logic [7:0] expected_version;
		logic [15:0] payload_limit;
		logic [15:0] timeout_limit_ms;
	} cfg_t;

endpackage

`default_nettype wire

>>> rtl/crcfd_crc_byte.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfd_crc_byte (
	input wire logic [15:0] crc,
	input wire logic [7:0] data,
	output logic [15:0] crc_next
);

	always_comb begin
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ crcfd_pkg::CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		crc_next = c;
	end

endmodule

`default_nettype wire

>>> rtl/crcfd_parser.sv
`timescale 1ns / 1ps
`default_nettype none

module crcfd_parser (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic go,
	input wire crcfd_pkg::in_t item,
	input wire crcfd_pkg::cfg_t cfg,
	output crcfd_pkg::out_t res
);

	crcfd_pkg::phase_t phase_q, phase_d;
	logic [31:0] start_q, start_d;
	logic [15:0] crc_q, crc_d;
	logic [7:0] crc_lo_q, crc_lo_d;
	logic [7:0] version_q, version_d;
	logic [7:0] type_q, type_d;
	logic [15:0] seq_q, seq_d;
	logic [15:0] len_q, len_d;
	logic [15:0] count_q, count_d;

	logic [15:0] crc_upd;
	logic [31:0] elapsed;
	logic [15:0] new_len;
	logic [15:0] count_inc;
	logic [15:0] got_crc;

	crcfd_crc_byte u_crc (
		.crc(crc_q),
		.data(item.rx_byte),
		.crc_next(crc_upd)
	);

	assign elapsed = item.now_ms - start_q;
	assign new_len = {item.rx_byte, len_q[7:0]};
	assign count_inc = count_q + 16'd1;
	assign got_crc = {item.rx_byte, crc_lo_q};

	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		crc_d = crc_q;
		crc_lo_d = crc_lo_q;
		version_d = version_q;
		type_d = type_q;
		seq_d = seq_q;
		len_d = len_q;
		count_d = count_q;
		res = '0;
		res.status = crcfd_pkg::ST_NEED_MORE;
		case (item.mode)
			crcfd_pkg::MODE_TIME: begin
				res.timeout_hit = (phase_q != crcfd_pkg::PH_SYNC0)
					&& (elapsed > {16'h0000, cfg.timeout_limit_ms});
			end
			crcfd_pkg::MODE_ABORT: begin
				phase_d = crcfd_pkg::PH_SYNC0;
				count_d = '0;
			end
			crcfd_pkg::MODE_RX: begin
				case (phase_q)
					crcfd_pkg::PH_SYNC0: begin
						if (item.rx_byte == crcfd_pkg::SYNC_A) begin
							phase_d = crcfd_pkg::PH_SYNC1;
							start_d = item.now_ms;
						end
					end
					crcfd_pkg::PH_SYNC1: begin
						if (item.rx_byte == crcfd_pkg::SYNC_B) begin
							phase_d = crcfd_pkg::PH_VER;
							crc_d = crcfd_pkg::CRC_INIT;
						end else if (item.rx_byte == crcfd_pkg::SYNC_A) begin
							start_d = item.now_ms;
						end else begin
							phase_d = crcfd_pkg::PH_SYNC0;
						end
					end
					crcfd_pkg::PH_VER: begin
						version_d = item.rx_byte;
						crc_d = crc_upd;
						phase_d = crcfd_pkg::PH_TYPE;
					end
					crcfd_pkg::PH_TYPE: begin
						type_d = item.rx_byte;
						crc_d = crc_upd;
						phase_d = crcfd_pkg::PH_SEQLO;
					end
					crcfd_pkg::PH_SEQLO: begin
						seq_d = {8'h00, item.rx_byte};
						crc_d = crc_upd;
						phase_d = crcfd_pkg::PH_SEQHI;
					end
					crcfd_pkg::PH_SEQHI: begin
						seq_d = {item.rx_byte, seq_q[7:0]};
						crc_d = crc_upd;
						phase_d = crcfd_pkg::PH_LENLO;
					end
					crcfd_pkg::PH_LENLO: begin
						len_d = {8'h00, item.rx_byte};
						crc_d = crc_upd;
						phase_d = crcfd_pkg::PH_LENHI;
					end
					crcfd_pkg::PH_LENHI: begin
						len_d = new_len;
						crc_d = crc_upd;
						count_d = '0;
						if (new_len > cfg.payload_limit) begin
							phase_d = crcfd_pkg::PH_SYNC0;
							res.status = crcfd_pkg::ST_LENGTH_ERR;
						end else if (new_len == 16'h0000) begin
							phase_d = crcfd_pkg::PH_CRCLO;
						end else begin
							phase_d = crcfd_pkg::PH_PAY;
						end
					end
					crcfd_pkg::PH_PAY: begin
						res.payload_valid = 1'b1;
						res.payload_byte = item.rx_byte;
						res.payload_index = count_q;
						crc_d = crc_upd;
						count_d = count_inc;
						if (count_inc >= len_q) begin
							phase_d = crcfd_pkg::PH_CRCLO;
						end
					end
					crcfd_pkg::PH_CRCLO: begin
						crc_lo_d = item.rx_byte;
						phase_d = crcfd_pkg::PH_CRCHI;
					end
					crcfd_pkg::PH_CRCHI: begin
						phase_d = crcfd_pkg::PH_SYNC0;
						count_d = '0;
						if (got_crc != crc_q) begin
							res.status = crcfd_pkg::ST_CRC_ERR;
						end else if (version_q != cfg.expected_version) begin
							res.status = crcfd_pkg::ST_VERSION_ERR;
						end else begin
							res.status = crcfd_pkg::ST_FRAME_READY;
							res.frame_type = type_q;
							res.frame_seq = seq_q;
							res.frame_len = len_q;
						end
					end
					default: begin
						phase_d = crcfd_pkg::PH_SYNC0;
						count_d = '0;
					end
				endcase
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= crcfd_pkg::PH_SYNC0;
			start_q <= '0;
			crc_q <= crcfd_pkg::CRC_INIT;
			crc_lo_q <= '0;
			version_q <= '0;
			type_q <= '0;
			seq_q <= '0;
			len_q <= '0;
			count_q <= '0;
		end else if (go) begin
			phase_q <= phase_d;
			start_q <= start_d;
			crc_q <= crc_d;
			crc_lo_q <= crc_lo_d;
			version_q <= version_d;
			type_q <= type_d;
			seq_q <= seq_d;
			len_q <= len_d;
			count_q <= count_d;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		go && item.mode == crcfd_pkg::MODE_ABORT |=> phase_q == crcfd_pkg::PH_SYNC0)
		else $error("abort did not return to sync hunt");

	assert property (@(posedge clk) disable iff (!arst_n)
		go && item.mode == crcfd_pkg::MODE_TIME |=> $stable(phase_q) && $stable(crc_q))
		else $error("timeout check changed parser state");

	assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == crcfd_pkg::PH_PAY |-> count_q < len_q)
		else $error("payload count reached length inside payload");

endmodule

`default_nettype wire

>>> rtl/crc_framed_packet_deframer.sv
// Frame deframer for a serial byte stream: sync A5 5A, version, type,
// sequence (lo, hi), length (lo, hi), payload, CRC16-CCITT-FALSE (lo, hi).
// Input channel in_valid/in_stall/in_data carries one item per transfer:
// a received byte, a timeout check at a given millisecond time, or an abort.
// Output channel out_valid/out_stall/out_data returns exactly one result per
// input item, in order; payload bytes stream out as they arrive.
// Path: an item is captured in the input register, then the parser step
// moves it into the result register, from which it transfers out unless
// the receiver stalls.
// Throughput: one item per cycle unless the receiver stalls; the byte-wide
// CRC update and parse step sit between the input and result registers.
// When the receiver stalls, the result register holds, and the input register
// holds one more item; in_stall rises once both are full.
// Config: wr_en, wr_index, wr_data write expected_version (0), payload_limit
// (1), timeout_limit_ms (2); the user writes only while idle, not enforced.
// Reset loads version 1, limit 256, timeout 20 ms, and leaves the parser
// hunting for the first sync byte with both registers empty.
`timescale 1ns / 1ps
`default_nettype none

module crc_framed_packet_deframer (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_stall,
	input wire crcfd_pkg::in_t in_data,
	output logic out_valid,
	input wire logic out_stall,
	output crcfd_pkg::out_t out_data,
	input wire logic wr_en,
	input wire logic [crcfd_pkg::CFG_IDX_W-1:0] wr_index,
	input wire logic [crcfd_pkg::CFG_W-1:0] wr_data
);

	crcfd_pkg::cfg_t cfg_q;
	logic valid_s1;
	crcfd_pkg::in_t item_s1;
	logic advance;
	crcfd_pkg::out_t res;
	logic valid_s2;
	crcfd_pkg::out_t res_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.expected_version <= crcfd_pkg::VERSION_RST;
			cfg_q.payload_limit <= crcfd_pkg::PAYLOAD_LIMIT_RST;
			cfg_q.timeout_limit_ms <= crcfd_pkg::TIMEOUT_LIMIT_RST;
		end else if (wr_en) begin
			case (wr_index)
				crcfd_pkg::CFG_VERSION: cfg_q.expected_version <= wr_data[7:0];
				crcfd_pkg::CFG_PAYLOAD_LIMIT: cfg_q.payload_limit <= wr_data;
				crcfd_pkg::CFG_TIMEOUT_LIMIT: cfg_q.timeout_limit_ms <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign advance = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			item_s1 <= in_data;
		end
	end

	crcfd_parser u_parser (
		.clk(clk),
		.arst_n(arst_n),
		.go(advance),
		.item(item_s1),
		.cfg(cfg_q),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign out_valid = valid_s2;
	assign out_data = res_s2;

	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> valid_s1 && valid_s2 && out_stall)
		else $error("input stalled with room in the pipeline");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !in_stall |=> valid_s2)
		else $error("advanced item produced no result");

	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && (res_s2.payload_valid || res_s2.timeout_hit)
		|-> res_s2.status == crcfd_pkg::ST_NEED_MORE)
		else $error("payload or timeout result carries a frame status");

endmodule

`default_nettype wire
